// ===== rtl/core/aged_four_way_hash_table_assert.svh =====
// assertion macros shared by the table rtl
// expects clk_i and rst_ni in the module that includes it
`ifndef AGED_FOUR_WAY_HASH_TABLE_ASSERT_SVH
`define AGED_FOUR_WAY_HASH_TABLE_ASSERT_SVH

`ifndef ASSERT_OFF
`define AWHT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define AWHT_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define AWHT_ASSERT(lbl, prop, msg)
`define AWHT_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

// ===== rtl/core/awht_pkg.sv =====
// types and constants for the aged four-way hash table
// no dependencies
`timescale 1ns / 1ps

package awht_pkg;

  localparam int WAYS           = 4;
  localparam int WAY_BITS       = $clog2(WAYS);
  localparam int MAX_INDEX_BITS = 16;
  localparam int ENTRY_BITS     = MAX_INDEX_BITS + WAY_BITS;
  localparam int IDX_CFG_W      = 5;
  localparam int GENERATIONS    = 8;
  localparam int GEN_BITS       = $clog2(GENERATIONS);
  localparam int AGE_SHIFT      = 7;   // age weight of 128
  localparam int DEPTH_W        = 7;
  localparam int SCORE_W        = GEN_BITS + AGE_SHIFT + 1;

  typedef enum logic [1:0] {
    CMD_PROBE   = 2'd0,
    CMD_STORE   = 2'd1,
    CMD_ADVANCE = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [63:0]        key;
    logic [31:0]        move_in;
    logic signed [7:0]  depth_in;
    logic signed [15:0] score_in;
    logic [1:0]         bound_in;
    logic               threat_in;
  } item_t;

  typedef struct packed {
    logic               hit;
    logic               evicted;
    logic [31:0]        move_out;
    logic [6:0]         depth_out;
    logic signed [15:0] score_out;
    logic [1:0]         bound_out;
    logic               threat_out;
  } result_t;

  typedef struct packed {
    logic [63:0]         tag;
    logic [31:0]         move;
    logic [DEPTH_W-1:0]  depth;
    logic [15:0]         score;
    logic [1:0]          bound;
    logic                threat;
    logic [GEN_BITS-1:0] age;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== rtl/core/awht_ram.sv =====
// single-port table memory with registered read data
// generic, no package dependencies
`timescale 1ns / 1ps

module awht_ram #(
  parameter int ADDR_W = 18,
  parameter int DATA_W = 125
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/aged_four_way_hash_table.sv =====
// aged four-way hash table: control sequencer, shared compare/score unit
// depends on awht_pkg, awht_ram and aged_four_way_hash_table_assert.svh
`timescale 1ns / 1ps
`include "aged_four_way_hash_table_assert.svh"

// Usage:
//   An item (probe, store, advance generation) is taken at a rising edge with
//   start high and busy low. Its result appears on result_o for exactly one
//   cycle with done_o high; the receiver cannot stall and must take it then.
//   The user writes index_bits_used via cfg_we_i/cfg_wdata_i only while idle; the block does not enforce it.
// Sequence:
//   The ways of the bucket are read one at a time from a single-port memory
//   (read, then compare and score in one shared unit).
//   Advance or unused command: done_o in the cycle after acceptance.
//   Probe hit or store match in way k: ways up to k are read, then way k is written.
//   Probe miss: all four ways, no write. Store without match: all four, then a write.
//   busy drops in the cycle done_o is shown, so a new item can follow at once.
// Reset:
//   The generation returns to zero and index_bits_used to 16; then a clearing
//   pass zeroes all 262144 table entries, one entry a cycle, with busy high.
//   Configuration writes are taken during the pass.

module aged_four_way_hash_table (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  awht_pkg::item_t                 item_i,
  output logic                            done_o,
  output awht_pkg::result_t               result_o,
  input  logic                            cfg_we_i,
  input  logic [awht_pkg::IDX_CFG_W-1:0]  cfg_wdata_i
);

  import awht_pkg::*;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_READ  = 5'b00100,
    ST_EVAL  = 5'b01000,
    ST_WRITE = 5'b10000
  } state_e;

  state_e                    state_q, state_d;
  logic [ENTRY_BITS-1:0]     clr_addr_q, clr_addr_d;
  logic [GEN_BITS-1:0]       gen_q, gen_d;
  logic [IDX_CFG_W-1:0]      idx_bits_q;
  item_t                     item_q, item_d;
  logic [MAX_INDEX_BITS-1:0] bucket_q, bucket_d;
  logic [WAY_BITS-1:0]       way_q, way_d;
  logic [WAY_BITS-1:0]       best_way_q, best_way_d;
  logic signed [SCORE_W-1:0] best_score_q, best_score_d;
  logic                      hit_q, hit_d;
  logic                      evict_q, evict_d;
  result_t                   res_q, res_d;
  logic                      done_q, done_d;

  logic                      ram_we, ram_re;
  logic [ENTRY_BITS-1:0]     ram_addr;
  entry_t                    ram_wdata, rd;
  logic [IDX_CFG_W-1:0]      bits_eff;
  logic [MAX_INDEX_BITS-1:0] idx_mask;
  logic [GEN_BITS-1:0]       age_gap;
  logic signed [SCORE_W-1:0] way_score;
  logic                      tag_match, tag_live, last_way, better;

  // bucket index mask from the clamped register value
  assign bits_eff = (idx_bits_q > IDX_CFG_W'(MAX_INDEX_BITS)) ?
                    IDX_CFG_W'(MAX_INDEX_BITS) : idx_bits_q;

  always_comb begin
    for (int i = 0; i < MAX_INDEX_BITS; i++) begin
      idx_mask[i] = (IDX_CFG_W'(i) < bits_eff);
    end
  end

  // shared compare and replacement score unit, one way per evaluation
  assign tag_match = (rd.tag == item_q.key);
  assign tag_live  = (rd.tag != '0);
  assign age_gap   = gen_q - rd.age;
  assign way_score = $signed({1'b0, age_gap, {AGE_SHIFT{1'b0}}})
                   - $signed({{(SCORE_W-DEPTH_W){1'b0}}, rd.depth});
  assign better    = (way_q == '0) || (way_score > best_score_q);
  assign last_way  = (way_q == WAY_BITS'(WAYS - 1));

  always_comb begin
    state_d      = state_q;
    clr_addr_d   = clr_addr_q;
    gen_d        = gen_q;
    item_d       = item_q;
    bucket_d     = bucket_q;
    way_d        = way_q;
    best_way_d   = best_way_q;
    best_score_d = best_score_q;
    hit_d        = hit_q;
    evict_d      = evict_q;
    res_d        = res_q;
    done_d       = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_addr     = {bucket_q, way_q};
    ram_wdata    = '0;

    case (state_q)
      ST_CLEAR: begin
        ram_we     = 1'b1;
        ram_addr   = clr_addr_q;
        clr_addr_d = clr_addr_q + 1'b1;
        if (clr_addr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          item_d   = item_i;
          bucket_d = item_i.key[MAX_INDEX_BITS-1:0] & idx_mask;
          way_d    = '0;
          hit_d    = 1'b0;
          evict_d  = 1'b0;
          res_d    = '0;
          case (item_i.cmd)
            CMD_PROBE, CMD_STORE: begin
              state_d = ST_READ;
            end
            CMD_ADVANCE: begin
              gen_d  = gen_q + 1'b1;
              done_d = 1'b1;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        ram_re  = 1'b1;
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (item_q.cmd == CMD_PROBE) begin
          if (tag_live && tag_match) begin
            best_way_d = way_q;
            hit_d      = 1'b1;
            state_d    = ST_WRITE;
          end else if (last_way) begin
            res_d   = '0;
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end else begin
            way_d   = way_q + 1'b1;
            state_d = ST_READ;
          end
        end else begin
          if (tag_match) begin
            best_way_d = way_q;
            hit_d      = 1'b1;
            evict_d    = 1'b0;
            state_d    = ST_WRITE;
          end else begin
            if (better) begin
              best_way_d   = way_q;
              best_score_d = way_score;
              evict_d      = tag_live && (rd.age == gen_q);
            end
            if (last_way) begin
              state_d = ST_WRITE;
            end else begin
              way_d   = way_q + 1'b1;
              state_d = ST_READ;
            end
          end
        end
      end
      ST_WRITE: begin
        ram_we   = 1'b1;
        ram_addr = {bucket_q, best_way_q};
        res_d    = '0;
        if (item_q.cmd == CMD_PROBE) begin
          // restamp the hit way, data from the read register
          ram_wdata           = rd;
          ram_wdata.age       = gen_q;
          res_d.hit           = 1'b1;
          res_d.move_out      = rd.move;
          res_d.depth_out     = rd.depth;
          res_d.score_out     = $signed(rd.score);
          res_d.bound_out     = rd.bound;
          res_d.threat_out    = rd.threat;
        end else begin
          ram_wdata.tag    = item_q.key;
          ram_wdata.move   = item_q.move_in;
          ram_wdata.depth  = item_q.depth_in[7] ? '0 : item_q.depth_in[DEPTH_W-1:0];
          ram_wdata.score  = item_q.score_in;
          ram_wdata.bound  = item_q.bound_in;
          ram_wdata.threat = item_q.threat_in;
          ram_wdata.age    = gen_q;
          res_d.hit        = hit_q;
          res_d.evicted    = evict_q;
        end
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  awht_ram #(
    .ADDR_W(ENTRY_BITS),
    .DATA_W(ENTRY_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (ram_re),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_addr_q <= '0;
      gen_q      <= '0;
      idx_bits_q <= IDX_CFG_W'(MAX_INDEX_BITS);
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
      gen_q      <= gen_d;
      done_q     <= done_d;
      if (cfg_we_i) begin
        idx_bits_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q       <= item_d;
    bucket_q     <= bucket_d;
    way_q        <= way_d;
    best_way_q   <= best_way_d;
    best_score_q <= best_score_d;
    hit_q        <= hit_d;
    evict_q      <= evict_d;
    res_q        <= res_d;
  end

  assign busy     = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

  `AWHT_ASSERT(a_advance_done, (start && !busy && item_i.cmd == CMD_ADVANCE) |=> done_o, "advance item gave no result")
  `AWHT_ASSERT(a_write_done, (state_q == ST_WRITE) |=> done_o, "table write not followed by a result")
  `AWHT_ASSERT_NEVER(a_hit_evict, done_o && result_o.hit && result_o.evicted, "hit and evicted together")
  `AWHT_ASSERT(a_miss_zero, (done_o && !result_o.hit) |-> (result_o.move_out == '0), "miss carries payload")

endmodule
